// ----- rtl/pso_pkg.sv -----
// Shared types and constants for the periodic sine overlay block.
// Holds the fixed-point constants, the Horner divisor tables and the
// multiplier control struct. No dependencies.
package pso_pkg;

  // fractional turn bits produced by the phase divider
  localparam int PHASE_BITS = 48;

  // configuration register indexes
  localparam int REG_IDX_W = 1;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_PERIOD    = 1'b0;
  localparam reg_idx_t REG_AMPLITUDE = 1'b1;

  localparam logic [63:0]  ONE_Q61    = 64'h2000_0000_0000_0000;
  localparam logic [63:0]  TWO_PI_Q61 = 64'hC90F_DAA2_2168_C235;
  localparam logic [46:0]  QUARTER    = 47'h4000_0000_0000;
  localparam logic [127:0] RND_HALF   = 128'h1000_0000_0000_0000;

  // reciprocals 2^66 / d, floor, used for the Horner divisions
  localparam logic [66:0] POW66   = 67'd1 << 66;
  localparam logic [63:0] RECIP_7 = 64'(POW66 / 67'd210);
  localparam logic [63:0] RECIP_6 = 64'(POW66 / 67'd156);
  localparam logic [63:0] RECIP_5 = 64'(POW66 / 67'd110);
  localparam logic [63:0] RECIP_4 = 64'(POW66 / 67'd72);
  localparam logic [63:0] RECIP_3 = 64'(POW66 / 67'd42);
  localparam logic [63:0] RECIP_2 = 64'(POW66 / 67'd20);
  localparam logic [63:0] RECIP_1 = 64'(POW66 / 67'd6);

  typedef struct packed {
    logic start;
    logic rnd;     // preload one half LSB of the Q61 result
  } mul_ctl_t;

  // (2k)(2k+1) for Horner step k
  function automatic logic [7:0] horner_div(input logic [2:0] k);
    logic [7:0] d;
    case (k)
      3'd7:    d = 8'd210;
      3'd6:    d = 8'd156;
      3'd5:    d = 8'd110;
      3'd4:    d = 8'd72;
      3'd3:    d = 8'd42;
      3'd2:    d = 8'd20;
      3'd1:    d = 8'd6;
      default: d = 8'd6;
    endcase
    return d;
  endfunction

  function automatic logic [63:0] horner_recip(input logic [2:0] k);
    logic [63:0] m;
    case (k)
      3'd7:    m = RECIP_7;
      3'd6:    m = RECIP_6;
      3'd5:    m = RECIP_5;
      3'd4:    m = RECIP_4;
      3'd3:    m = RECIP_3;
      3'd2:    m = RECIP_2;
      3'd1:    m = RECIP_1;
      default: m = RECIP_1;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/pso_div_cell.sv -----
// One restoring division step: shift in a dividend bit, compare, subtract.
// Cells are chained in pso_phase_div. No package dependencies.
module pso_div_cell #(
  parameter int W = 16
) (
  input  logic [W-1:0] rem_in,
  input  logic         bit_in,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] rem_out,
  output logic         q_bit
);

  logic [W:0] shifted;
  logic [W:0] diff;

  assign shifted = {rem_in, bit_in};
  assign diff    = shifted - {1'b0, divisor};
  assign q_bit   = (shifted >= {1'b0, divisor});
  assign rem_out = q_bit ? diff[W-1:0] : shifted[W-1:0];

endmodule

// ----- rtl/pso_phase_div.sv -----
// Phase divider: (n * 2^48) / p by restoring division, a chain of division
// cells advancing several quotient bits per cycle. Keeps the low 48 quotient
// bits (the turn fraction). Uses pso_pkg and pso_div_cell.
module pso_phase_div #(
  parameter int PERIOD_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [PERIOD_BITS-1:0]           dividend,
  input  logic [PERIOD_BITS-1:0]           divisor,   // nonzero
  output logic                             done,
  output logic [pso_pkg::PHASE_BITS-1:0]   phase
);

  localparam int DIV_CELLS = 4;
  localparam int RAW_BITS  = PERIOD_BITS + pso_pkg::PHASE_BITS;
  localparam int DIV_BITS  = ((RAW_BITS + DIV_CELLS - 1) / DIV_CELLS) * DIV_CELLS;
  localparam int STEPS     = DIV_BITS / DIV_CELLS;
  localparam int CNT_W     = $clog2(STEPS);
  localparam int PB        = pso_pkg::PHASE_BITS;

  logic [PERIOD_BITS-1:0] rem_r;
  logic [PERIOD_BITS-1:0] dsr_r;
  logic [DIV_BITS-1:0]    dvd_r;
  logic [PB-1:0]          quo_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   busy_r;
  logic                   done_r;

  logic [PERIOD_BITS-1:0] rem_c [DIV_CELLS+1];
  logic [DIV_CELLS-1:0]   q_bits;

  assign rem_c[0] = rem_r;

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_cell
    pso_div_cell #(.W(PERIOD_BITS)) u_cell (
      .rem_in  (rem_c[j]),
      .bit_in  (dvd_r[DIV_BITS-1-j]),
      .divisor (dsr_r),
      .rem_out (rem_c[j+1]),
      .q_bit   (q_bits[DIV_CELLS-1-j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(STEPS - 1));
      if (start) begin
        rem_r  <= '0;
        dsr_r  <= divisor;
        dvd_r  <= DIV_BITS'({dividend, {PB{1'b0}}});
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_c[DIV_CELLS];
        dvd_r <= dvd_r << DIV_CELLS;
        quo_r <= {quo_r[PB-1-DIV_CELLS:0], q_bits};
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  assign done  = done_r;
  assign phase = quo_r;

endmodule

// ----- rtl/pso_mul64.sv -----
// 64 x 64 multiplier built from one 32 x 32 multiplier that forms the four
// partial products in turn, with an optional rounding preload of the
// 128-bit accumulator. Uses pso_pkg (mul_ctl_t, RND_HALF).
module pso_mul64 (
  input  logic              clk,
  input  logic              rst_n,
  input  pso_pkg::mul_ctl_t ctl,
  input  logic [63:0]       op_a,
  input  logic [63:0]       op_b,
  output logic              done,
  output logic [127:0]      prod
);

  localparam logic [2:0] LAST_STEP = 3'd4;

  logic         busy_r;
  logic         done_r;
  logic [2:0]   cnt_r;
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [63:0]  pp_r;
  logic [1:0]   pp_idx_r;
  logic [127:0] acc_r;

  logic [31:0]  a_sel;
  logic [31:0]  b_sel;
  logic [63:0]  pp_nxt;
  logic [127:0] pp_ext;

  assign a_sel  = cnt_r[1] ? a_r[63:32] : a_r[31:0];
  assign b_sel  = cnt_r[0] ? b_r[63:32] : b_r[31:0];
  assign pp_nxt = a_sel * b_sel;

  always_comb begin
    case (pp_idx_r)
      2'd0:    pp_ext = {64'd0, pp_r};
      2'd1:    pp_ext = {32'd0, pp_r, 32'd0};
      2'd2:    pp_ext = {32'd0, pp_r, 32'd0};
      2'd3:    pp_ext = {pp_r, 64'd0};
      default: pp_ext = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !ctl.start && busy_r && (cnt_r == LAST_STEP);
      if (ctl.start) begin
        a_r    <= op_a;
        b_r    <= op_b;
        acc_r  <= ctl.rnd ? pso_pkg::RND_HALF : '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r != LAST_STEP) begin
          pp_r     <= pp_nxt;
          pp_idx_r <= cnt_r[1:0];
        end
        // partial product of the previous cycle lands here
        if (cnt_r != 3'd0) acc_r <= acc_r + pp_ext;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ----- rtl/periodic_sine_overlay_core.sv -----
// Periodic sine overlay: out = sat32(base + amplitude * sin(2*pi*n/P)).
// Input items arrive on in_* (base sample, Q16.16); each gives one result item
// on out_* (saturated sum on out_tdata, clip flag on out_tuser). Configuration
// is written through cfg_we/cfg_addr/cfg_wdata: period (index 0), amplitude
// (index 1, Q16.16).
// One item is in flight at a time; in_tready is high only between items.
// From accept to out_tvalid, the phase divider runs first (four division
// cells in its chain), then 18 products on the shared 64x64 multiplier with
// Horner quotient correction between them, then the sum.
// The multiplier sequence sets the rate; no new item is accepted until the
// previous one has left the sum state.
// A finished result waits in the output register while out_tready is low; the
// next item is accepted meanwhile and the block holds its own result until
// that register frees up.
// Reset (rst_n, synchronous) clears the tick counter, sets period to 1 and
// amplitude to 0, and drops out_tvalid.
// Depends on pso_pkg, pso_phase_div, pso_div_cell, pso_mul64.
module periodic_sine_overlay_core #(
  parameter int PERIOD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,    // [31:0] base_sample
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,   // [31:0] out_sample
  output logic                          out_tuser,   // [0] clipped
  input  logic                          cfg_we,
  input  logic [pso_pkg::REG_IDX_W-1:0] cfg_addr,
  input  logic [31:0]                   cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_MX, ST_MX2, ST_MT, ST_MR, ST_QD, ST_CORR, ST_MS, ST_MA, ST_SUM
  } state_t;

  state_t                 state_r;
  logic [15:0]            period_r;
  logic [31:0]            amp_r;
  logic [PERIOD_BITS-1:0] tick_r;
  logic [31:0]            base_r;
  logic                   neg_s_r;
  logic [63:0]            x_r;
  logic [63:0]            x2_r;
  logic [63:0]            a_r;
  logic [63:0]            qe_r;
  logic [63:0]            qd_r;
  logic [2:0]             k_r;
  logic [32:0]            mag_r;
  logic                   out_tvalid_r;
  logic [31:0]            out_sample_r;
  logic                   out_clip_r;

  // effective period: masked to PERIOD_BITS, zero used as one
  logic [PERIOD_BITS+15:0] period_ext;
  logic [PERIOD_BITS-1:0]  p_raw;
  logic [PERIOD_BITS-1:0]  p_eff;
  logic [PERIOD_BITS-1:0]  tick_nxt;
  logic                    in_fire;
  logic                    out_load;

  logic                            div_done;
  logic [pso_pkg::PHASE_BITS-1:0]  phase;
  logic [46:0]                     f_quad;

  pso_pkg::mul_ctl_t mul_ctl;
  logic [63:0]       mul_a;
  logic [63:0]       mul_b;
  logic              mul_done;
  logic [127:0]      prod;

  logic [7:0]  d_k;
  logic [71:0] qd_full;
  logic [63:0] rem;
  logic [63:0] pq;
  logic [63:0] t_nxt;
  logic [31:0] amag;

  logic [34:0] base_ext;
  logic [34:0] mag_ext;
  logic [34:0] sum;
  logic        clip;
  logic [31:0] sat;

  assign period_ext = {{PERIOD_BITS{1'b0}}, period_r};
  assign p_raw      = period_ext[PERIOD_BITS-1:0];
  assign p_eff      = (p_raw == '0) ? PERIOD_BITS'(1) : p_raw;
  assign tick_nxt   = (tick_r >= p_eff - PERIOD_BITS'(1)) ? '0 : tick_r + PERIOD_BITS'(1);

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_SUM) && (!out_tvalid_r || out_tready);

  pso_phase_div #(.PERIOD_BITS(PERIOD_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .dividend (tick_r),
    .divisor  (p_eff),
    .done     (div_done),
    .phase    (phase)
  );

  // fold into the first quadrant
  assign f_quad = phase[46] ? (pso_pkg::QUARTER - {1'b0, phase[45:0]}) : {1'b0, phase[45:0]};

  pso_mul64 u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  // Horner step: p = floor(x2*t / d), estimate from the reciprocal is low by
  // at most one
  assign d_k     = pso_pkg::horner_div(k_r);
  assign qd_full = qe_r * d_k;
  assign rem     = a_r - qd_r;
  assign pq      = (rem >= {56'd0, d_k}) ? qe_r + 64'd1 : qe_r;
  assign t_nxt   = (pq > pso_pkg::ONE_Q61) ? '0 : pso_pkg::ONE_Q61 - pq;

  assign amag = amp_r[31] ? (~amp_r + 32'd1) : amp_r;

  always_comb begin
    mul_ctl = '0;
    mul_a   = '0;
    mul_b   = '0;
    case (state_r)
      ST_DIV: begin
        if (div_done) begin
          mul_ctl.start = 1'b1;
          mul_a         = {17'd0, f_quad};
          mul_b         = pso_pkg::TWO_PI_Q61;
        end
      end
      ST_MX: begin
        if (mul_done) begin
          mul_ctl.start = 1'b1;
          mul_a         = prod[111:48];
          mul_b         = prod[111:48];
        end
      end
      ST_MX2: begin
        if (mul_done) begin
          mul_ctl.start = 1'b1;
          mul_a         = prod[124:61];
          mul_b         = pso_pkg::ONE_Q61;
        end
      end
      ST_MT: begin
        if (mul_done) begin
          mul_ctl.start = 1'b1;
          mul_a         = prod[124:61];
          mul_b         = pso_pkg::horner_recip(k_r);
        end
      end
      ST_CORR: begin
        mul_ctl.start = 1'b1;
        mul_a         = (k_r == 3'd1) ? x_r : x2_r;
        mul_b         = t_nxt;
      end
      ST_MS: begin
        if (mul_done) begin
          mul_ctl.start = 1'b1;
          mul_ctl.rnd   = 1'b1;
          mul_a         = {32'd0, amag};
          mul_b         = prod[124:61];
        end
      end
      default: ;
    endcase
  end

  assign base_ext = {{3{base_r[31]}}, base_r};
  assign mag_ext  = {2'b00, mag_r};
  assign sum      = (neg_s_r ^ amp_r[31]) ? base_ext - mag_ext : base_ext + mag_ext;
  assign clip     = !(sum[34:31] == 4'b0000 || sum[34:31] == 4'b1111);
  assign sat      = clip ? (sum[34] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      period_r     <= 16'd1;
      amp_r        <= '0;
      tick_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          pso_pkg::REG_PERIOD:    period_r <= cfg_wdata[15:0];
          pso_pkg::REG_AMPLITUDE: amp_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_load) out_tvalid_r <= 1'b1;
      else if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            base_r  <= in_tdata;
            tick_r  <= tick_nxt;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            neg_s_r <= phase[47];
            state_r <= ST_MX;
          end
        end
        ST_MX: begin
          if (mul_done) begin
            x_r     <= prod[111:48];
            state_r <= ST_MX2;
          end
        end
        ST_MX2: begin
          if (mul_done) begin
            x2_r    <= prod[124:61];
            k_r     <= 3'd7;
            state_r <= ST_MT;
          end
        end
        ST_MT: begin
          if (mul_done) begin
            a_r     <= prod[124:61];
            state_r <= ST_MR;
          end
        end
        ST_MR: begin
          if (mul_done) begin
            qe_r    <= {2'b00, prod[127:66]};
            state_r <= ST_QD;
          end
        end
        ST_QD: begin
          qd_r    <= qd_full[63:0];
          state_r <= ST_CORR;
        end
        ST_CORR: begin
          if (k_r == 3'd1) begin
            state_r <= ST_MS;
          end else begin
            k_r     <= k_r - 3'd1;
            state_r <= ST_MT;
          end
        end
        ST_MS: begin
          if (mul_done) state_r <= ST_MA;
        end
        ST_MA: begin
          if (mul_done) begin
            mag_r   <= prod[93:61];
            state_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (out_load) begin
            out_sample_r <= sat;
            out_clip_r   <= clip;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_sample_r;
  assign out_tuser  = out_clip_r;

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for periodic_sine_overlay_core: a bit-exact sine-overlay
// predictor checks every result item through the stream ports.
// Depends on pso_pkg (register indexes) and the core RTL.
module tb_top;

  localparam logic [63:0] ONE_Q61     = 64'h2000_0000_0000_0000;
  localparam logic [63:0] TWO_PI_Q61  = 64'hC90F_DAA2_2168_C235;
  localparam logic [63:0] QTR_TURN    = 64'h0000_4000_0000_0000;
  localparam logic [127:0] HALF_LSB   = 128'h1000_0000_0000_0000;
  localparam longint SAT_MAX = 64'sd2147483647;
  localparam longint SAT_MIN = -64'sd2147483648;
  localparam int BURST_ITEMS = 128;
  localparam int HOLD_CYCLES = 3000;
  localparam int TAIL_CYCLES = 300;

  typedef struct packed {
    logic [31:0] sample;
    logic        clipped;
  } overlay_result_t;

  class sine_overlay_scoreboard;
    logic [15:0] period_reg = 16'd1;
    logic [31:0] amp_reg = 32'd0;
    logic [15:0] tick = 16'd0;
    overlay_result_t pending[$];
    int errors = 0;

    function void set_reg(pso_pkg::reg_idx_t idx, logic [31:0] v);
      if (idx == pso_pkg::REG_PERIOD)
        period_reg = v[15:0];
      else
        amp_reg = v;
    endfunction

    // (a*b + rnd) >> sh, truncated to 64 bits
    function logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, logic [127:0] rnd,
                                    int unsigned sh);
      logic [127:0] full;
      full = 128'(a) * 128'(b) + rnd;
      return 64'(full >> sh);
    endfunction

    // |sin| in Q61 for an angle in [0, quarter turn], 2^-48 turn units
    function logic [63:0] sine_mag(logic [63:0] f);
      logic [63:0] x, x2, t, prod, d;
      x = mul_shift(f, TWO_PI_Q61, 128'd0, 48);
      x2 = mul_shift(x, x, 128'd0, 61);
      t = ONE_Q61;
      for (int k = 7; k >= 1; k--) begin
        d = 64'((2 * k) * (2 * k + 1));
        prod = mul_shift(x2, t, 128'd0, 61) / d;
        t = (prod > ONE_Q61) ? 64'd0 : ONE_Q61 - prod;
      end
      return mul_shift(x, t, 128'd0, 61);
    endfunction

    function void note_input(logic [31:0] base);
      logic [63:0] p_eff, n, r, ph, f, s, mag;
      logic [1:0] quad;
      logic neg_s, neg_a;
      longint base_v, mag_v, sum;
      overlay_result_t res;
      p_eff = (period_reg == 16'd0) ? 64'd1 : 64'(period_reg);
      n = 64'(tick);
      r = n % p_eff;
      ph = 64'd0;
      for (int i = 0; i < 48; i++) begin
        r = r << 1;
        ph = ph << 1;
        if (r >= p_eff) begin
          r = r - p_eff;
          ph[0] = 1'b1;
        end
      end
      quad = ph[47:46];
      f = {18'd0, ph[45:0]};
      if (quad[0])
        f = QTR_TURN - f;
      neg_s = quad[1];
      s = sine_mag(f);
      neg_a = amp_reg[31];
      mag = neg_a ? (64'h1_0000_0000 - {32'd0, amp_reg}) : {32'd0, amp_reg};
      mag = mul_shift(mag, s, HALF_LSB, 61);
      base_v = longint'(signed'(base));
      mag_v = longint'(mag);
      sum = (neg_s != neg_a) ? base_v - mag_v : base_v + mag_v;
      res.clipped = 1'b0;
      if (sum > SAT_MAX) begin
        sum = SAT_MAX;
        res.clipped = 1'b1;
      end else if (sum < SAT_MIN) begin
        sum = SAT_MIN;
        res.clipped = 1'b1;
      end
      res.sample = sum[31:0];
      pending.push_back(res);
      // counter left beyond a lowered period wraps here too
      if (n >= p_eff - 64'd1)
        tick = 16'd0;
      else
        tick = tick + 16'd1;
    endfunction

    function void check(logic [31:0] sample, logic clipped);
      overlay_result_t exp_res;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item: sample %h clipped %b", $time, sample, clipped);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (sample !== exp_res.sample) begin
        $display("%0t: out_sample mismatch: expected %h actual %h", $time,
                 exp_res.sample, sample);
        errors++;
      end
      if (clipped !== exp_res.clipped) begin
        $display("%0t: clipped mismatch: expected %b actual %b", $time,
                 exp_res.clipped, clipped);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = 32'd0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic [pso_pkg::REG_IDX_W-1:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = 32'd0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  logic hold_on = 1'b0;

  sine_overlay_scoreboard sb = new();

  periodic_sine_overlay_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [31:0] base_sample
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // [31:0] out_sample
    .out_tuser  (out_tuser),    // [0] clipped
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #25_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // result side: check accepted items, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check(out_tdata, out_tuser);
    if (hold_on)
      out_tready <= 1'b0;
    else
      out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [31:0] pick_base();
    case ($urandom_range(9))
      0, 1:    return 32'h7FFF_FFFF - $urandom_range(255);
      2, 3:    return 32'h8000_0000 + $urandom_range(255);
      4, 5:    return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_amp();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(32'h0010_0000) - 32'h0008_0000;
      2:       return 32'h7FFF_FFFF - $urandom_range(65535);
      default: return 32'h8000_0000 + $urandom_range(65535);
    endcase
  endfunction

  task automatic write_reg(input pso_pkg::reg_idx_t idx, input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [31:0] v);
    in_tvalid <= 1'b1;
    in_tdata <= v;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    sb.note_input(v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(200, 1)) @(posedge clk);
    end
  endtask

  task automatic send_burst(input int count);
    for (int i = 0; i < count; i++)
      send_sample(pick_base());
    in_tvalid <= 1'b0;
  endtask

  task automatic send_list(input logic [31:0] vals[$]);
    foreach (vals[i])
      send_sample(vals[i]);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pending.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic hold_output(input int cycles);
    hold_on <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_on <= 1'b0;
  endtask

  initial begin
    logic [15:0] per;
    logic [31:0] amp;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: no overlay
    send_list('{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    wait_idle();
    // quarter-turn steps: sine 0, +1, 0, -1 with full-scale amplitude
    write_reg(pso_pkg::REG_PERIOD, 32'd4);
    write_reg(pso_pkg::REG_AMPLITUDE, 32'h7FFF_FFFF);
    send_list('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000});
    wait_idle();
    write_reg(pso_pkg::REG_AMPLITUDE, 32'h8000_0000);
    send_list('{32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF});
    wait_idle();
    // zero period acts as one; upper write bits are dropped
    write_reg(pso_pkg::REG_PERIOD, 32'hA5A5_0000);
    write_reg(pso_pkg::REG_AMPLITUDE, 32'h0001_0000);
    send_list('{32'h0000_0001, 32'hFFFF_0000});
    wait_idle();
    // run to tick 5, then lower the period under the counter
    write_reg(pso_pkg::REG_PERIOD, 32'd8);
    send_list('{32'h0000_0000, 32'h0001_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001});
    wait_idle();
    write_reg(pso_pkg::REG_PERIOD, 32'd3);
    send_list('{32'h0000_0000, 32'h0000_0000});
    wait_idle();
    // tiny amplitude on a long period: product rounds to nothing
    write_reg(pso_pkg::REG_PERIOD, 32'h0000_FFFF);
    write_reg(pso_pkg::REG_AMPLITUDE, 32'd1);
    send_list('{32'h0000_0000, 32'hFFFF_FFFF, 32'h5A5A_5A5A});

    for (int seg = 0; seg < 8; seg++) begin
      wait_idle();
      case (seg)
        0: begin
          per = 16'd13;
          amp = 32'h7FFF_FFFF;
        end
        1: begin
          per = 16'hFFFF;
          amp = 32'h8000_0000;
        end
        5: begin
          per = 16'd0;
          amp = pick_amp();
        end
        default: begin
          per = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(64, 1));
          amp = pick_amp();
        end
      endcase
      write_reg(pso_pkg::REG_PERIOD, {16'($urandom), per});
      write_reg(pso_pkg::REG_AMPLITUDE, amp);
      case (seg % 4)
        0: begin
          send_idle_pct <= 0;
          stall_pct <= 0;
        end
        1: begin
          send_idle_pct <= 80;
          stall_pct <= 0;
        end
        2: begin
          send_idle_pct <= 0;
          stall_pct <= 80;
        end
        default: begin
          send_idle_pct <= 31;
          stall_pct <= 31;
        end
      endcase
      if (seg == 0) begin
        // long output hold-off while items keep coming: input must back up
        fork
          hold_output(HOLD_CYCLES);
          send_burst(BURST_ITEMS);
        join
      end else begin
        send_burst(BURST_ITEMS);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
